[hw/rtl/tdlz_pkg.sv]
package tdlz_pkg;

  localparam int AW    = 8;
  localparam int DEPTH = 256;

  localparam logic [7:0] TOK_EXT = 8'hff;
  localparam logic [8:0] LEN_MAX = 9'd256;

  typedef enum logic [3:0] {
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_SKIP_A,
    PH_SKIP_B,
    PH_COUNT,
    PH_TABLE,
    PH_TOKEN,
    PH_REF_LEN,
    PH_EXT_LEN,
    PH_LITERAL,
    PH_LIT_OVER,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_COPY,
    SQ_STATUS
  } seq_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_DIST = 2'd2,
    ST_OVERRUN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

[hw/rtl/tdlz_ram.sv]
// 256x8, one write and one read port, registered read, write-first on collision.
module tdlz_ram (
  input  logic               clk,
  input  tdlz_pkg::ram_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] mem_r [tdlz_pkg::DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rd_data_r <= req.wdata;
      end else begin
        rd_data_r <= mem_r[req.raddr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/table_distance_lz_decompressor.sv]
// Table-distance LZ decompressor, one compressed byte per input transfer.
//
// Input stream: in_tdata carries the file byte, in_tlast marks the file's final
// byte. Output stream: out_tdata carries up to four decompressed bytes and a
// byte count, out_tuser the status, out_tlast ends a file's output or error.
//
// A literal byte shows up on the output the cycle after its transfer. A
// back-reference of length L holds in_tready low after its length byte until
// the copy of its L bytes ends: the copy reads and writes the 256-byte history
// memory one byte per cycle unless a result waits on a full output register,
// and emits a result every BYTES_PER_RESULT bytes and after its last byte. A
// truncation status, when due, follows the last data result one transfer later.
//
// Results wait in a single output register. An input transfer or a copy result
// needs that register free (empty, or being taken in the same cycle), so while
// the receiver stalls with a result pending, the input side pauses and the copy
// stops at its next result. Reset returns the parser to the start of a header;
// memories are not cleared.
module table_distance_lz_decompressor #(
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_data, [34:32] out_count, rest zero
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [1:0] out_status
);

  localparam int CW = $clog2(BYTES_PER_RESULT + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(BYTES_PER_RESULT - 1);

  tdlz_pkg::phase_t  phase_r, phase_nxt;
  tdlz_pkg::seq_t    seq_r, seq_nxt;
  logic [15:0]       decl_r, decl_nxt;
  logic [15:0]       prod_r, prod_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [7:0]        tcount_r, tcount_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic [8:0]        lit_left_r, lit_left_nxt;
  logic [7:0]        src_r, dst_r;
  logic [8:0]        left_r;
  logic              fin_r, trunc_pend_r;
  logic [31:0]       acc_r;
  logic [CW-1:0]     acc_cnt_r;
  tdlz_pkg::result_t out_r, out_nxt;
  logic              out_valid_r;
  logic              out_load;

  tdlz_pkg::ram_req_t dtab_req, hist_req;
  logic [7:0]         dtab_rd, hist_rd;

  logic              in_acc, out_free;
  logic [7:0]        b;
  logic [8:0]        ref_len, short_len, ref_dist;
  logic [7:0]        copy_src;
  logic              ended, enter_body, body_empty, start_copy, copy_fin, trunc;
  logic              lit_we;
  logic              imm_vld;
  tdlz_pkg::result_t imm_res;

  logic              last_byte, flush, step;
  logic [31:0]       acc_word;
  logic [CW:0]       cnt_p1;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (seq_r == tdlz_pkg::SQ_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign ref_len   = (b == 8'd0) ? tdlz_pkg::LEN_MAX : {1'b0, b};
  assign short_len = {1'b0, b} - {1'b0, tcount_r} + 9'd1;
  assign ref_dist  = {1'b0, dtab_rd} + 9'd1;
  assign copy_src  = prod_r[7:0] - ref_dist[7:0];

  // Parser decode for the byte being transferred.
  always_comb begin
    phase_nxt    = phase_r;
    decl_nxt     = decl_r;
    prod_nxt     = prod_r;
    rem_nxt      = rem_r;
    tcount_nxt   = tcount_r;
    fill_nxt     = fill_r;
    lit_left_nxt = lit_left_r;
    ended        = 1'b0;
    enter_body   = 1'b0;
    body_empty   = 1'b0;
    start_copy   = 1'b0;
    copy_fin     = 1'b0;
    lit_we       = 1'b0;
    imm_vld      = 1'b0;
    imm_res      = '0;
    dtab_req     = '0;
    unique case (phase_r)
      tdlz_pkg::PH_SIZE_LO: begin
        decl_nxt  = {8'h00, b};
        phase_nxt = tdlz_pkg::PH_SIZE_HI;
      end
      tdlz_pkg::PH_SIZE_HI: begin
        decl_nxt  = {b, decl_r[7:0]};
        phase_nxt = tdlz_pkg::PH_SKIP_A;
      end
      tdlz_pkg::PH_SKIP_A: phase_nxt = tdlz_pkg::PH_SKIP_B;
      tdlz_pkg::PH_SKIP_B: phase_nxt = tdlz_pkg::PH_COUNT;
      tdlz_pkg::PH_COUNT: begin
        tcount_nxt = b;
        fill_nxt   = 8'd0;
        prod_nxt   = 16'd0;
        rem_nxt    = decl_r;
        if (b == 8'd0) begin
          enter_body = 1'b1;
          body_empty = (decl_r == 16'd0);
        end else begin
          phase_nxt = tdlz_pkg::PH_TABLE;
        end
      end
      tdlz_pkg::PH_TABLE: begin
        dtab_req.we    = in_acc;
        dtab_req.waddr = fill_r;
        dtab_req.wdata = b;
        fill_nxt       = fill_r + 8'd1;
        if ((fill_r + 8'd1) == tcount_r) begin
          enter_body = 1'b1;
          body_empty = (rem_r == 16'd0);
        end
      end
      tdlz_pkg::PH_TOKEN: begin
        if (b < tcount_r) begin
          dtab_req.re    = in_acc;
          dtab_req.raddr = b;
          phase_nxt      = tdlz_pkg::PH_REF_LEN;
        end else if (b == tdlz_pkg::TOK_EXT) begin
          phase_nxt = tdlz_pkg::PH_EXT_LEN;
        end else begin
          lit_left_nxt = short_len;
          phase_nxt    = (16'(short_len) > rem_r) ? tdlz_pkg::PH_LIT_OVER
                                                  : tdlz_pkg::PH_LITERAL;
        end
      end
      tdlz_pkg::PH_REF_LEN: begin
        if (16'(ref_dist) > prod_r) begin
          imm_vld        = 1'b1;
          imm_res.last   = 1'b1;
          imm_res.status = tdlz_pkg::ST_BAD_DIST;
          ended          = 1'b1;
        end else if (16'(ref_len) > rem_r) begin
          imm_vld        = 1'b1;
          imm_res.last   = 1'b1;
          imm_res.status = tdlz_pkg::ST_OVERRUN;
          ended          = 1'b1;
        end else begin
          start_copy = 1'b1;
          copy_fin   = (16'(ref_len) == rem_r);
          prod_nxt   = prod_r + 16'(ref_len);
          rem_nxt    = rem_r - 16'(ref_len);
          if (copy_fin) begin
            ended = 1'b1;
          end else begin
            phase_nxt = tdlz_pkg::PH_TOKEN;
          end
        end
      end
      tdlz_pkg::PH_EXT_LEN: begin
        lit_left_nxt = ref_len;
        phase_nxt    = (16'(ref_len) > rem_r) ? tdlz_pkg::PH_LIT_OVER
                                              : tdlz_pkg::PH_LITERAL;
      end
      tdlz_pkg::PH_LITERAL: begin
        lit_we        = 1'b1;
        prod_nxt      = prod_r + 16'd1;
        rem_nxt       = rem_r - 16'd1;
        lit_left_nxt  = lit_left_r - 9'd1;
        imm_vld       = 1'b1;
        imm_res.data  = {24'h000000, b};
        imm_res.count = 3'd1;
        imm_res.last  = (rem_r == 16'd1);
        if (rem_r == 16'd1) begin
          ended = 1'b1;
        end else if (lit_left_r == 9'd1) begin
          phase_nxt = tdlz_pkg::PH_TOKEN;
        end
      end
      tdlz_pkg::PH_LIT_OVER: begin
        lit_left_nxt = lit_left_r - 9'd1;
        if (lit_left_r == 9'd1) begin
          imm_vld        = 1'b1;
          imm_res.last   = 1'b1;
          imm_res.status = tdlz_pkg::ST_OVERRUN;
          ended          = 1'b1;
        end
      end
      tdlz_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (enter_body) begin
      if (body_empty) begin
        imm_vld      = 1'b1;
        imm_res.last = 1'b1;
        ended        = 1'b1;
      end else begin
        phase_nxt = tdlz_pkg::PH_TOKEN;
      end
    end

    trunc = in_tlast && !ended && (phase_r != tdlz_pkg::PH_DONE);

    if (ended) begin
      phase_nxt = in_tlast ? tdlz_pkg::PH_SIZE_LO : tdlz_pkg::PH_DONE;
    end else if (in_tlast) begin
      phase_nxt = tdlz_pkg::PH_SIZE_LO;
    end
  end

  // Copy datapath: one history byte per step.
  assign last_byte = (left_r == 9'd1);
  assign flush     = last_byte || (acc_cnt_r == CNT_LAST);
  assign step      = (seq_r == tdlz_pkg::SQ_COPY) && (!flush || out_free);
  assign cnt_p1    = {1'b0, acc_cnt_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    acc_word = acc_r;
    for (int i = 0; i < 4; i++) begin
      if (32'(acc_cnt_r) == 32'(i)) begin
        acc_word[8*i +: 8] = hist_rd;
      end
    end
  end

  always_comb begin
    hist_req = '0;
    if (seq_r == tdlz_pkg::SQ_COPY) begin
      hist_req.we    = step;
      hist_req.waddr = dst_r;
      hist_req.wdata = hist_rd;
      hist_req.re    = step && !last_byte;
      hist_req.raddr = src_r;
    end else begin
      hist_req.we    = in_acc && lit_we;
      hist_req.waddr = prod_r[7:0];
      hist_req.wdata = b;
      hist_req.re    = in_acc && start_copy;
      hist_req.raddr = copy_src;
    end
  end

  // Sequencer next state.
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      tdlz_pkg::SQ_IDLE: begin
        if (in_acc) begin
          if (start_copy) begin
            seq_nxt = tdlz_pkg::SQ_COPY;
          end else if (imm_vld && trunc) begin
            seq_nxt = tdlz_pkg::SQ_STATUS;
          end
        end
      end
      tdlz_pkg::SQ_COPY: begin
        if (step && last_byte) begin
          seq_nxt = trunc_pend_r ? tdlz_pkg::SQ_STATUS : tdlz_pkg::SQ_IDLE;
        end
      end
      tdlz_pkg::SQ_STATUS: begin
        if (out_free) begin
          seq_nxt = tdlz_pkg::SQ_IDLE;
        end
      end
      default: seq_nxt = tdlz_pkg::SQ_IDLE;
    endcase
  end

  // Output register load.
  always_comb begin
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (seq_r)
      tdlz_pkg::SQ_IDLE: begin
        if (in_acc && imm_vld) begin
          out_load = 1'b1;
          out_nxt  = imm_res;
        end else if (in_acc && trunc && !start_copy) begin
          out_load       = 1'b1;
          out_nxt.last   = 1'b1;
          out_nxt.status = tdlz_pkg::ST_TRUNC;
        end
      end
      tdlz_pkg::SQ_COPY: begin
        if (step && flush) begin
          out_load      = 1'b1;
          out_nxt.data  = acc_word;
          out_nxt.count = 3'(cnt_p1);
          out_nxt.last  = fin_r && last_byte;
        end
      end
      tdlz_pkg::SQ_STATUS: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_nxt.last   = 1'b1;
          out_nxt.status = tdlz_pkg::ST_TRUNC;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tdlz_pkg::PH_SIZE_LO;
      seq_r       <= tdlz_pkg::SQ_IDLE;
      decl_r      <= '0;
      prod_r      <= '0;
      rem_r       <= '0;
      tcount_r    <= '0;
      fill_r      <= '0;
      lit_left_r  <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        decl_r     <= decl_nxt;
        prod_r     <= prod_nxt;
        rem_r      <= rem_nxt;
        tcount_r   <= tcount_nxt;
        fill_r     <= fill_nxt;
        lit_left_r <= lit_left_nxt;
      end
      if (in_acc && start_copy) begin
        left_r <= ref_len;
      end else if (step) begin
        left_r <= left_r - 9'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (in_acc && start_copy) begin
      src_r        <= copy_src + 8'd1;
      dst_r        <= prod_r[7:0];
      fin_r        <= copy_fin;
      trunc_pend_r <= trunc;
      acc_r        <= '0;
      acc_cnt_r    <= '0;
    end else if (step) begin
      src_r     <= src_r + 8'd1;
      dst_r     <= dst_r + 8'd1;
      acc_r     <= flush ? '0 : acc_word;
      acc_cnt_r <= flush ? '0 : CW'(cnt_p1);
    end
  end

  tdlz_ram u_dtab (
    .clk     (clk),
    .req     (dtab_req),
    .rd_data (dtab_rd)
  );

  tdlz_ram u_hist (
    .clk     (clk),
    .req     (hist_req),
    .rd_data (hist_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_r.count, out_r.data};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.status;

`ifndef SYNTHESIS
  a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == tdlz_pkg::SQ_COPY) |-> (left_r != 9'd0))
    else $error("copy running with no bytes left");

  a_status_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == tdlz_pkg::SQ_STATUS) |-> out_valid_r)
    else $error("pending status without a result ahead of it");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != tdlz_pkg::ST_OK))
      |-> ((out_r.count == 3'd0) && out_r.last))
    else $error("error result carries data or lacks last");

  a_size_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == tdlz_pkg::PH_TOKEN) || (phase_r == tdlz_pkg::PH_REF_LEN) ||
     (phase_r == tdlz_pkg::PH_EXT_LEN) || (phase_r == tdlz_pkg::PH_LITERAL) ||
     (phase_r == tdlz_pkg::PH_LIT_OVER)) |-> ((prod_r + rem_r) == decl_r))
    else $error("produced and remaining counts disagree with declared size");
`endif

endmodule
